[sv/bmp_pkg.sv]
package bmp_pkg;

  localparam int MaxN       = 4095;
  localparam int TableDepth = MaxN + 1;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int DataW      = 16;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusNoInv = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    StIdle,
    StCheck,
    StExt0,
    StExtRd,
    StExtChk,
    StExtWr,
    StRdR,
    StRdNr,
    StRdN,
    StRdEnd,
    StInvInit,
    StInvChk,
    StInvQ,
    StInvAcc,
    StFin1,
    StFin2,
    StFin3,
    StMul,
    StDivGo,
    StDivWait,
    StOut
  } state_e;

endpackage

[sv/bmp_ram.sv]
module bmp_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bmp_div.sv]
module bmp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o,
  output logic [15:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] trial;

  assign trial = {rem_q, quo_q[31]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = dividend_i;
      rem_d  = 16'd0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 16'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[15:0];
  assign rem_o  = rem_q;

endmodule

[sv/binomial_mod_prime_top.sv]
// Answers C(n, r) mod p for the prime p held in the modulus register (reset 2). Writing the
// modulus empties the factorial table; later queries extend it on demand up to the largest n
// seen, at most 4095. One query is in flight at a time and in_ready_o is low meanwhile. Queries
// settled by the early checks (r above n, r zero or equal to n, n out of range, modulus below 2)
// skip the table. Otherwise the cost is set by the one shared restoring divider: each new table
// entry takes one division, each step of the two inverse chains takes two (one for p divided by
// the current value, one for the product mod p), and the chain length depends on p and the
// factorial value; the reads and the two closing multiplications come on top. The table is
// never cleared: a fill count marks its valid entries. A finished result waits in an output
// register while the next query is taken.
module binomial_mod_prime_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] n_total_i,
  input  logic [15:0] r_chosen_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] value_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_modulus_i
);

  bmp_pkg::state_e  state_q, state_d;
  bmp_pkg::state_e  ret_q, ret_d;
  bmp_pkg::status_e res_st_q, res_st_d;
  bmp_pkg::status_e status_q, status_d;

  logic [15:0]              mod_q, mod_d;
  logic [bmp_pkg::CntW-1:0] filled_q, filled_d;
  logic [bmp_pkg::CntW-1:0] i_q, i_d;
  logic [bmp_pkg::CntW-1:0] filled_m1;
  logic [15:0] n_q, n_d, r_q, r_d, nr_diff;
  logic [15:0] prev_q, prev_d;
  logic [15:0] fr_q, fr_d, fnr_q, fnr_d, fn_q, fn_d;
  logic [15:0] iv_q, iv_d, acc_q, acc_d, inv_r_q, inv_r_d;
  logic        sel_q, sel_d;
  logic [15:0] opa_q, opa_d, opb_q, opb_d;
  logic [31:0] dvd_q, dvd_d;
  logic [15:0] dvs_q, dvs_d;
  logic [15:0] res_val_q, res_val_d;
  logic [15:0] value_q, value_d;
  logic        out_valid_q, out_valid_d;

  logic                      ram_we;
  logic [bmp_pkg::AddrW-1:0] ram_waddr, ram_raddr;
  logic [15:0]               ram_wdata, ram_rdata;

  logic        div_start, div_done;
  logic [15:0] div_quot, div_rem;

  bmp_ram #(
    .Width(bmp_pkg::DataW),
    .Depth(bmp_pkg::TableDepth)
  ) u_fact_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bmp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dvd_q),
    .divisor_i (dvs_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign nr_diff   = n_q - r_q;
  assign filled_m1 = filled_q - bmp_pkg::CntW'(1);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    mod_d       = mod_q;
    filled_d    = filled_q;
    i_d         = i_q;
    n_d         = n_q;
    r_d         = r_q;
    prev_d      = prev_q;
    fr_d        = fr_q;
    fnr_d       = fnr_q;
    fn_d        = fn_q;
    iv_d        = iv_q;
    acc_d       = acc_q;
    inv_r_d     = inv_r_q;
    sel_d       = sel_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    value_d     = value_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      bmp_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d     = n_total_i;
          r_d     = r_chosen_i;
          state_d = bmp_pkg::StCheck;
        end
      end
      bmp_pkg::StCheck: begin
        res_val_d = 16'd0;
        res_st_d  = bmp_pkg::StatusOk;
        if (r_q > n_q) begin
          state_d = bmp_pkg::StOut;
        end else if (r_q == 16'd0 || r_q == n_q) begin
          res_val_d = 16'd1;
          state_d   = bmp_pkg::StOut;
        end else if (n_q > 16'(bmp_pkg::MaxN)) begin
          res_st_d = bmp_pkg::StatusRange;
          state_d  = bmp_pkg::StOut;
        end else if (mod_q < 16'd2) begin
          res_st_d = bmp_pkg::StatusNoInv;
          state_d  = bmp_pkg::StOut;
        end else if (16'(filled_q) > n_q) begin
          state_d = bmp_pkg::StRdR;
        end else if (filled_q == '0) begin
          state_d = bmp_pkg::StExt0;
        end else begin
          ram_raddr = filled_m1[bmp_pkg::AddrW-1:0];
          state_d   = bmp_pkg::StExtRd;
        end
      end
      bmp_pkg::StExt0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = 16'd1;
        prev_d    = 16'd1;
        i_d       = bmp_pkg::CntW'(1);
        filled_d  = bmp_pkg::CntW'(1);
        state_d   = bmp_pkg::StExtChk;
      end
      bmp_pkg::StExtRd: begin
        prev_d  = ram_rdata;
        i_d     = filled_q;
        state_d = bmp_pkg::StExtChk;
      end
      bmp_pkg::StExtChk: begin
        if (16'(i_q) > n_q) begin
          state_d = bmp_pkg::StRdR;
        end else begin
          opa_d   = prev_q;
          opb_d   = 16'(i_q);
          ret_d   = bmp_pkg::StExtWr;
          state_d = bmp_pkg::StMul;
        end
      end
      bmp_pkg::StExtWr: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[bmp_pkg::AddrW-1:0];
        ram_wdata = div_rem;
        prev_d    = div_rem;
        i_d       = i_q + bmp_pkg::CntW'(1);
        filled_d  = i_q + bmp_pkg::CntW'(1);
        state_d   = bmp_pkg::StExtChk;
      end
      bmp_pkg::StRdR: begin
        ram_raddr = r_q[bmp_pkg::AddrW-1:0];
        state_d   = bmp_pkg::StRdNr;
      end
      bmp_pkg::StRdNr: begin
        ram_raddr = nr_diff[bmp_pkg::AddrW-1:0];
        fr_d      = ram_rdata;
        state_d   = bmp_pkg::StRdN;
      end
      bmp_pkg::StRdN: begin
        ram_raddr = n_q[bmp_pkg::AddrW-1:0];
        fnr_d     = ram_rdata;
        state_d   = bmp_pkg::StRdEnd;
      end
      bmp_pkg::StRdEnd: begin
        fn_d    = ram_rdata;
        sel_d   = 1'b0;
        state_d = bmp_pkg::StInvInit;
      end
      bmp_pkg::StInvInit: begin
        iv_d    = sel_q ? fnr_q : fr_q;
        acc_d   = 16'd1;
        state_d = bmp_pkg::StInvChk;
      end
      bmp_pkg::StInvChk: begin
        if (iv_q == 16'd1) begin
          if (!sel_q) begin
            inv_r_d = acc_q;
            sel_d   = 1'b1;
            state_d = bmp_pkg::StInvInit;
          end else begin
            state_d = bmp_pkg::StFin1;
          end
        end else if (iv_q == 16'd0) begin
          res_val_d = 16'd0;
          res_st_d  = bmp_pkg::StatusNoInv;
          state_d   = bmp_pkg::StOut;
        end else begin
          dvd_d   = {16'd0, mod_q};
          dvs_d   = iv_q;
          ret_d   = bmp_pkg::StInvQ;
          state_d = bmp_pkg::StDivGo;
        end
      end
      bmp_pkg::StInvQ: begin
        iv_d    = div_rem;
        opa_d   = acc_q;
        opb_d   = mod_q - div_quot;
        ret_d   = bmp_pkg::StInvAcc;
        state_d = bmp_pkg::StMul;
      end
      bmp_pkg::StInvAcc: begin
        acc_d   = div_rem;
        state_d = bmp_pkg::StInvChk;
      end
      bmp_pkg::StFin1: begin
        opa_d   = fn_q;
        opb_d   = inv_r_q;
        ret_d   = bmp_pkg::StFin2;
        state_d = bmp_pkg::StMul;
      end
      bmp_pkg::StFin2: begin
        opa_d   = div_rem;
        opb_d   = acc_q;
        ret_d   = bmp_pkg::StFin3;
        state_d = bmp_pkg::StMul;
      end
      bmp_pkg::StFin3: begin
        res_val_d = div_rem;
        res_st_d  = bmp_pkg::StatusOk;
        state_d   = bmp_pkg::StOut;
      end
      bmp_pkg::StMul: begin
        dvd_d   = {16'd0, opa_q} * {16'd0, opb_q};
        dvs_d   = mod_q;
        state_d = bmp_pkg::StDivGo;
      end
      bmp_pkg::StDivGo: begin
        div_start = 1'b1;
        state_d   = bmp_pkg::StDivWait;
      end
      bmp_pkg::StDivWait: begin
        if (div_done) begin
          state_d = ret_q;
        end
      end
      bmp_pkg::StOut: begin
        if (!out_valid_q || out_ready_i) begin
          value_d     = res_val_q;
          status_d    = res_st_q;
          out_valid_d = 1'b1;
          state_d     = bmp_pkg::StIdle;
        end
      end
      default: begin
        state_d = bmp_pkg::StIdle;
      end
    endcase

    if (cfg_valid_i) begin
      mod_d    = cfg_modulus_i;
      filled_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmp_pkg::StIdle;
      ret_q       <= bmp_pkg::StIdle;
      mod_q       <= 16'd2;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      mod_q       <= mod_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    n_q       <= n_d;
    r_q       <= r_d;
    prev_q    <= prev_d;
    fr_q      <= fr_d;
    fnr_q     <= fnr_d;
    fn_q      <= fn_d;
    iv_q      <= iv_d;
    acc_q     <= acc_d;
    inv_r_q   <= inv_r_d;
    sel_q     <= sel_d;
    opa_q     <= opa_d;
    opb_q     <= opb_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    value_q   <= value_d;
    status_q  <= status_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  a_err_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bmp_pkg::StatusOk) |-> value_o == 16'd0)
    else $error("error word carries a nonzero value");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bmp_pkg::StDivWait)
    else $error("divider finished outside its wait state");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= bmp_pkg::CntW'(bmp_pkg::TableDepth))
    else $error("fill count beyond table depth");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

endmodule
